// File: design/epst_pkg.sv
// Shared types and constants for the encoder position step trigger.
// No dependencies; every other design file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package epst_pkg;

   // Counter width and payload field widths
   localparam int POSITION_BITS = 16;
   localparam int POS_FIELD_BITS = 16;
   localparam int STEP_BITS = 15;
   localparam int LIMIT_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;

   // Window compare width: holds distance plus step without overflow
   localparam int CMP_BITS =
      ((POSITION_BITS > STEP_BITS) ? POSITION_BITS : STEP_BITS) + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register indexes on the write port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SIZE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_LIMIT = 1'b1;

   // Input item commands
   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef struct packed {
      command_type                command;
      logic [POS_FIELD_BITS-1:0]  position;
   } item_type;

   typedef struct packed {
      logic                   trigger_level;
      logic                   fired;
      logic                   moved_up;
      logic [COUNT_BITS-1:0]  trigger_index;
      logic                   running;
   } result_type;

endpackage

`default_nettype wire

// File: design/epst_req_if.sv
// Input channel: valid/ready handshake carrying command and position.
// Depends on epst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface epst_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [epst_pkg::POS_FIELD_BITS-1:0] position;

   modport source (output valid, output command, output position, input ready);
   modport sink   (input valid, input command, input position, output ready);
endinterface

`default_nettype wire

// File: design/epst_rsp_if.sv
// Result channel: valid/ready handshake carrying trigger status fields.
// Depends on epst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface epst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            trigger_level;
   logic                            fired;
   logic                            moved_up;
   logic [epst_pkg::COUNT_BITS-1:0] trigger_index;
   logic                            running;

   modport source (output valid, output trigger_level, output fired,
                   output moved_up, output trigger_index, output running,
                   input ready);
   modport sink   (input valid, input trigger_level, input fired,
                   input moved_up, input trigger_index, input running,
                   output ready);
endinterface

`default_nettype wire

// File: design/epst_core.sv
// Trigger state registers and the per-beat window compare / update logic.
// Depends on epst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epst_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step_en,
   input  wire epst_pkg::item_type                 item,
   input  wire logic [epst_pkg::STEP_BITS-1:0]     step_size,
   input  wire logic [epst_pkg::LIMIT_BITS-1:0]    trigger_limit,
   output      epst_pkg::result_type               result
);

   localparam int PB = epst_pkg::POSITION_BITS;
   localparam int CB = epst_pkg::CMP_BITS;
   localparam logic [CB-1:0] POS_RANGE = CB'(1) << PB;

   logic [PB-1:0]                      ref_ff, ref_in;
   logic [epst_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                               level_ff, level_in;
   logic                               active_ff, active_in;
   logic                               up_ff, up_in;

   logic [PB-1:0]                      pos;
   logic [PB-1:0]                      offset;
   logic [CB-1:0]                      dist_ext;
   logic [CB-1:0]                      step_ext;
   logic [CB-1:0]                      far_sum;
   logic                               outside;
   logic                               fire;
   logic [epst_pkg::COUNT_BITS-1:0]    count_base;
   logic [epst_pkg::COUNT_BITS-1:0]    count_fired;

   // Wrapped distance from the reference and window test
   assign pos      = PB'(item.position);
   assign offset   = pos - ref_ff;
   assign dist_ext = CB'(offset);
   assign step_ext = CB'(step_size);
   assign far_sum  = dist_ext + step_ext;
   assign outside  = (dist_ext >= step_ext) && (far_sum <= POS_RANGE);

   // Saturating count, restarted from zero on a start beat
   assign count_base  = (item.command == epst_pkg::CMD_START) ? '0 : count_ff;
   assign count_fired = (count_base == epst_pkg::COUNT_MAX) ? count_base
                                                            : count_base + 1'b1;

   // Next state for the beat in the input register
   always_comb begin
      ref_in    = ref_ff;
      count_in  = count_ff;
      level_in  = level_ff;
      active_in = active_ff;
      up_in     = up_ff;
      fire      = 1'b0;
      case (item.command)
         epst_pkg::CMD_START: begin
            ref_in    = pos;
            up_in     = 1'b0;
            active_in = 1'b1;
            fire      = 1'b1;
         end
         epst_pkg::CMD_SAMPLE: begin
            if (active_ff && outside) begin
               fire = 1'b1;
               // upper half of the range means the sample lies below
               if (!offset[PB-1]) begin
                  ref_in = ref_ff + PB'(step_size);
                  up_in  = 1'b1;
               end else begin
                  ref_in = ref_ff - PB'(step_size);
                  up_in  = 1'b0;
               end
               if (count_fired >= trigger_limit) begin
                  active_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (fire) begin
         count_in = count_fired;
         level_in = ~level_ff;
      end
   end

   // Result reflects state after this beat
   always_comb begin
      result.trigger_level = level_in;
      result.fired         = fire;
      result.moved_up      = up_in;
      result.trigger_index = count_in;
      result.running       = active_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         count_ff  <= '0;
         level_ff  <= 1'b0;
         active_ff <= 1'b0;
         up_ff     <= 1'b0;
      end else if (step_en) begin
         ref_ff    <= ref_in;
         count_ff  <= count_in;
         level_ff  <= level_in;
         active_ff <= active_in;
         up_ff     <= up_in;
      end
   end

   // A start beat always opens a run with one trigger
   a_start_opens_run: assert property (@(posedge clock) disable iff (reset)
      step_en && item.command == epst_pkg::CMD_START
      |=> active_ff && count_ff == epst_pkg::COUNT_BITS'(1))
      else $error("start beat did not open a run with count one");

   // Trigger line toggles exactly when a beat fires
   a_level_tracks_fire: assert property (@(posedge clock) disable iff (reset)
      step_en |=> level_ff == ($past(level_ff) ^ $past(fire)))
      else $error("trigger level out of step with fired beats");

   // Samples never lower the count
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      step_en && item.command == epst_pkg::CMD_SAMPLE
      |=> count_ff >= $past(count_ff))
      else $error("trigger count went down on a sample beat");

   // An idle block ignores samples
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && !active_ff |-> !fire || item.command == epst_pkg::CMD_START)
      else $error("sample fired while no run active");

   // State holds between beats
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(ref_ff) && $stable(count_ff) && $stable(active_ff))
      else $error("trigger state changed without a beat");

endmodule

`default_nettype wire

// File: design/encoder_position_step_trigger_core.sv
// Top level of the encoder position step trigger: register file, input stage,
// result stage. Depends on epst_pkg, epst_req_if, epst_rsp_if and epst_core.
//
//  channel | direction | handshake          | beat contents
//  req     | in        | req.valid/ready    | command, position
//  rsp     | out       | rsp.valid/ready    | trigger_level, fired, moved_up,
//          |           |                    | trigger_index, running
//  csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One beat per cycle sustained while rsp.ready is high; a beat passes through
// the input register, then the result register, with the compare in between.
// The trigger state updates as a beat leaves the input register.
// Synchronous active-high reset clears both stages and the trigger state;
// step_size resets to 1, trigger_limit to 0.
// A stalled result holds the result register; the input register still takes
// one further beat, after which req.ready drops until rsp.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module encoder_position_step_trigger_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   epst_req_if.sink                                     req,
   epst_rsp_if.source                                   rsp,
   input  wire logic                                    csr_write_enable,
   input  wire logic [epst_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [epst_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   logic [epst_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [epst_pkg::LIMIT_BITS-1:0]   limit_ff, limit_in;

   logic                              in_valid_ff, in_valid_in;
   epst_pkg::item_type                in_item_ff, in_item_in;
   logic                              out_valid_ff, out_valid_in;
   epst_pkg::result_type              out_data_ff, out_data_in;

   epst_pkg::result_type              core_result;
   logic                              advance;
   logic                              req_take;

   // Configuration register writes
   always_comb begin
      step_in  = step_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            epst_pkg::CSR_STEP_SIZE:     step_in  = csr_write_data[epst_pkg::STEP_BITS-1:0];
            epst_pkg::CSR_TRIGGER_LIMIT: limit_in = csr_write_data[epst_pkg::LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= epst_pkg::STEP_BITS'(1);
         limit_ff <= '0;
      end else begin
         step_ff  <= step_in;
         limit_ff <= limit_in;
      end
   end

   // Handshake: a beat moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   // Input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in         = 1'b1;
         in_item_in.command  = epst_pkg::command_type'(req.command);
         in_item_in.position = req.position;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   // Window compare and trigger state
   epst_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (in_item_ff),
      .step_size     (step_ff),
      .trigger_limit (limit_ff),
      .result        (core_result)
   );

   // Result stage
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.trigger_level = out_data_ff.trigger_level;
   assign rsp.fired         = out_data_ff.fired;
   assign rsp.moved_up      = out_data_ff.moved_up;
   assign rsp.trigger_index = out_data_ff.trigger_index;
   assign rsp.running       = out_data_ff.running;

endmodule

`default_nettype wire
